@@ rtl/fmr_pkg.sv @@
package fmr_pkg;

  // Field widths
  localparam int IN_W    = 32;
  localparam int PROD_W  = 63;
  localparam int NUM_W   = 64;
  localparam int SHIFT_W = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic mul_den;
    logic gcd_init;
    logic gcd_step;
    logic g_load;
    logic g_shift;
    logic div_load;
    logic div_step;
    logic div_store;
    logic div_den;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic red_done;
    logic k_zero;
    logic g_zero;
  } stat_t;

endpackage

@@ rtl/fmr_ctrl.sv @@
module fmr_ctrl
  import fmr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MULN   = 4'd1;
  localparam logic [3:0] S_MULD   = 4'd2;
  localparam logic [3:0] S_GINIT  = 4'd3;
  localparam logic [3:0] S_GRED   = 4'd4;
  localparam logic [3:0] S_GSCALE = 4'd5;
  localparam logic [3:0] S_DLOAD  = 4'd6;
  localparam logic [3:0] S_DSTEP  = 4'd7;
  localparam logic [3:0] S_DSTORE = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic [SHIFT_W-1:0] LAST_BIT = SHIFT_W'(PROD_W - 1);

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [SHIFT_W-1:0] cnt;
  logic [SHIFT_W-1:0] cnt_next;
  logic               den_phase;
  logic               den_phase_next;
  logic               out_valid_next;

  assign in_stall = (state != S_IDLE);

  // Sequence: multiply, gcd, scale, then two divisions if gcd nonzero
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    den_phase_next = den_phase;
    out_valid_next = out_valid;
    cmd            = '0;
    cmd.div_den    = den_phase;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MULN;
        end
      end
      S_MULN: begin
        cmd.mul_en = 1'b1;
        state_next = S_MULD;
      end
      S_MULD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_den = 1'b1;
        state_next  = S_GINIT;
      end
      S_GINIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = S_GRED;
      end
      S_GRED: begin
        if (stat.red_done) begin
          cmd.g_load = 1'b1;
          state_next = S_GSCALE;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_GSCALE: begin
        if (!stat.k_zero) begin
          cmd.g_shift = 1'b1;
        end else if (stat.g_zero) begin
          state_next = S_OUT;
        end else begin
          den_phase_next = 1'b0;
          state_next     = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          state_next = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (den_phase) begin
          state_next = S_OUT;
        end else begin
          den_phase_next = 1'b1;
          state_next     = S_DLOAD;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      den_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      den_phase <= den_phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/fmr_dpath.sv @@
module fmr_dpath
  import fmr_pkg::*;
(
  input  logic                    clk,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic signed [IN_W-1:0]  first_numerator,
  input  logic signed [IN_W-1:0]  first_denominator,
  input  logic signed [IN_W-1:0]  second_numerator,
  input  logic signed [IN_W-1:0]  second_denominator,
  output logic signed [NUM_W-1:0] product_numerator,
  output logic [PROD_W-1:0]       product_denominator,
  output logic                    zero_gcd_error
);

  logic [IN_W-1:0]    n1m, n2m, d1m, d2m;
  logic               sn, sd;
  logic [PROD_W-1:0]  pn, pd;
  logic [PROD_W-1:0]  a, b, g;
  logic [SHIFT_W-1:0] k;
  logic [PROD_W-1:0]  dq, rem;
  logic [PROD_W-1:0]  rn, rd;

  logic [IN_W-1:0]    op_a, op_b;
  logic [NUM_W-1:0]   prod;
  logic [PROD_W:0]    a_sub_b;
  logic [PROD_W-1:0]  b_sub_a;
  logic [PROD_W:0]    trial;
  logic [PROD_W:0]    trial_sub;
  logic               neg;
  logic [NUM_W-1:0]   rn_ext;

  function automatic logic [IN_W-1:0] mag(input logic [IN_W-1:0] x);
    mag = x[IN_W-1] ? (~x + 1'b1) : x;
  endfunction

  // Shared 32x32 multiplier, operands chosen by phase
  assign op_a = cmd.mul_den ? d1m : n1m;
  assign op_b = cmd.mul_den ? d2m : n2m;
  assign prod = {{(NUM_W-IN_W){1'b0}}, op_a} * {{(NUM_W-IN_W){1'b0}}, op_b};

  // Binary gcd compare and subtract
  assign a_sub_b = {1'b0, a} - {1'b0, b};
  assign b_sub_a = b - a;

  // Restoring divider trial subtract against the gcd
  assign trial     = {rem, dq[PROD_W-1]};
  assign trial_sub = trial - {1'b0, g};

  assign stat.red_done = (a == '0) || (b == '0);
  assign stat.k_zero   = (k == '0);
  assign stat.g_zero   = (g == '0);

  // Sign goes to the numerator only when it is non-zero
  assign neg    = (rn != '0) && (sn ^ (sd && (rd != '0)));
  assign rn_ext = {1'b0, rn};

  always_ff @(posedge clk) begin
    // Capture magnitudes and sign parities
    if (cmd.load_in) begin
      n1m <= mag(first_numerator);
      d1m <= mag(first_denominator);
      n2m <= mag(second_numerator);
      d2m <= mag(second_denominator);
      sn  <= first_numerator[IN_W-1] ^ second_numerator[IN_W-1];
      sd  <= first_denominator[IN_W-1] ^ second_denominator[IN_W-1];
    end

    // Store products
    if (cmd.mul_en) begin
      if (cmd.mul_den) begin
        pd <= prod[PROD_W-1:0];
      end else begin
        pn <= prod[PROD_W-1:0];
      end
    end

    // Reduce by common and single factors of two, subtract when both odd
    if (cmd.gcd_init) begin
      a <= pn;
      b <= pd;
      k <= '0;
    end else if (cmd.gcd_step) begin
      if (!a[0] && !b[0]) begin
        a <= a >> 1;
        b <= b >> 1;
        k <= k + 1'b1;
      end else if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (!a_sub_b[PROD_W]) begin
        a <= a_sub_b[PROD_W-1:0];
      end else begin
        b <= b_sub_a;
      end
    end

    // Restore the common power of two into the gcd, one bit a cycle
    if (cmd.g_load) begin
      g <= a | b;
    end else if (cmd.g_shift) begin
      g <= {g[PROD_W-2:0], 1'b0};
      k <= k - 1'b1;
    end

    // Divide one product by the gcd, one quotient bit a cycle
    if (cmd.div_load) begin
      dq  <= cmd.div_den ? pd : pn;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!trial_sub[PROD_W]) begin
        rem <= trial_sub[PROD_W-1:0];
        dq  <= {dq[PROD_W-2:0], 1'b1};
      end else begin
        rem <= trial[PROD_W-1:0];
        dq  <= {dq[PROD_W-2:0], 1'b0};
      end
    end

    if (cmd.div_store) begin
      if (cmd.div_den) begin
        rd <= dq;
      end else begin
        rn <= dq;
      end
    end

    // Drive the result registers
    if (cmd.out_load) begin
      if (g == '0) begin
        product_numerator   <= '0;
        product_denominator <= '0;
        zero_gcd_error      <= 1'b1;
      end else begin
        product_numerator   <= neg ? -rn_ext : rn_ext;
        product_denominator <= rd;
        zero_gcd_error      <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/fraction_multiply_reduce_top.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    first_numerator, first_denominator,
//                                            second_numerator, second_denominator
// out      output     out_valid / out_stall  product_numerator, product_denominator,
//                                            zero_gcd_error
//
// One item at a time: after the two products, binary gcd steps run until one
// operand is zero, the gcd is shifted back over the common factors of two
// (at most 62), and two divisions follow on the one bit-serial divider.
// Both products zero: the divisions are skipped and zero_gcd_error is set.
// Reset (rst, synchronous) returns the controller to idle and drops out_valid.
// A stalled result is held in the output register; the next item may be
// accepted and worked on while it waits.
module fraction_multiply_reduce_top
  import fmr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  first_numerator,
  input  logic signed [IN_W-1:0]  first_denominator,
  input  logic signed [IN_W-1:0]  second_numerator,
  input  logic signed [IN_W-1:0]  second_denominator,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [NUM_W-1:0] product_numerator,
  output logic [PROD_W-1:0]       product_denominator,
  output logic                    zero_gcd_error
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence the item
  fmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Multiply, reduce and divide
  fmr_dpath u_dpath (
    .clk                 (clk),
    .cmd                 (cmd),
    .stat                (stat),
    .first_numerator     (first_numerator),
    .first_denominator   (first_denominator),
    .second_numerator    (second_numerator),
    .second_denominator  (second_denominator),
    .product_numerator   (product_numerator),
    .product_denominator (product_denominator),
    .zero_gcd_error      (zero_gcd_error)
  );

endmodule
